@@ design/ttx_pkg.sv @@
package ttx_pkg;

   localparam logic [6:0] SpaceCode      = 7'h20;
   localparam logic [6:0] AlphaFirst     = 7'h01;
   localparam logic [6:0] AlphaLast      = 7'h07;
   localparam logic [6:0] MosaicFirst    = 7'h11;
   localparam logic [6:0] MosaicLast     = 7'h17;
   localparam logic [6:0] CodeContiguous = 7'h19;
   localparam logic [6:0] CodeSeparated  = 7'h1A;
   localparam logic [6:0] CodeBlackBg    = 7'h1C;
   localparam logic [6:0] CodeNewBg      = 7'h1D;
   localparam logic [6:0] CodeHold       = 7'h1E;
   localparam logic [6:0] CodeRelease    = 7'h1F;
   localparam logic [2:0] ColourWhite    = 3'd7;
   localparam logic [2:0] ColourBlack    = 3'd0;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       row_start;
   } req_type;

   typedef struct packed {
      logic [6:0] shown_code;
      logic       is_mosaic;
      logic       is_control;
      logic       parity_error;
      logic [2:0] foreground;
      logic [2:0] background;
      logic       separated_cell;
   } rsp_type;

   typedef struct packed {
      logic [2:0] foreground_colour;
      logic [2:0] background_colour;
      logic       mosaic_mode;
      logic       hold_active;
      logic       separated_mode;
      logic [6:0] held_mosaic;
   } attr_state_type;

   localparam attr_state_type AttrReset = '{
      foreground_colour: ColourWhite,
      background_colour: ColourBlack,
      mosaic_mode:       1'b0,
      hold_active:       1'b0,
      separated_mode:    1'b0,
      held_mosaic:       SpaceCode
   };

endpackage

@@ design/ttx_decode.sv @@
module ttx_decode (
   input  ttx_pkg::req_type        req,
   input  logic                    ignore_parity,
   input  ttx_pkg::attr_state_type state_cur,
   output ttx_pkg::attr_state_type state_next,
   output ttx_pkg::rsp_type        rsp
);

   ttx_pkg::attr_state_type base;
   ttx_pkg::attr_state_type at_cell;
   logic                    bad;
   logic [6:0]              code;
   logic                    ctrl;

   always_comb begin
      base = req.row_start ? ttx_pkg::AttrReset : state_cur;
      bad  = ~(^req.code_byte);
      code = (bad && !ignore_parity) ? ttx_pkg::SpaceCode : req.code_byte[6:0];
      ctrl = (code[6:5] == 2'b00);

      at_cell = base;
      if (ctrl) begin
         case (code)
            ttx_pkg::CodeBlackBg:    at_cell.background_colour = ttx_pkg::ColourBlack;
            ttx_pkg::CodeNewBg:      at_cell.background_colour = base.foreground_colour;
            ttx_pkg::CodeHold:       at_cell.hold_active = 1'b1;
            ttx_pkg::CodeContiguous: at_cell.separated_mode = 1'b0;
            ttx_pkg::CodeSeparated:  at_cell.separated_mode = 1'b1;
            default: ;
         endcase
      end

      rsp.is_control     = ctrl;
      rsp.parity_error   = bad;
      rsp.foreground     = base.foreground_colour;
      rsp.background     = at_cell.background_colour;
      rsp.separated_cell = at_cell.separated_mode;
      if (ctrl) begin
         if (at_cell.hold_active && at_cell.mosaic_mode && at_cell.held_mosaic[5]) begin
            rsp.shown_code = at_cell.held_mosaic;
            rsp.is_mosaic  = 1'b1;
         end else begin
            rsp.shown_code = ttx_pkg::SpaceCode;
            rsp.is_mosaic  = at_cell.mosaic_mode;
         end
      end else begin
         rsp.shown_code = code;
         rsp.is_mosaic  = at_cell.mosaic_mode && code[5];
      end

      state_next = at_cell;
      if (ctrl) begin
         if (code inside {[ttx_pkg::AlphaFirst:ttx_pkg::AlphaLast]}) begin
            state_next.foreground_colour = code[2:0];
            state_next.mosaic_mode       = 1'b0;
            if (at_cell.mosaic_mode) begin
               state_next.held_mosaic = ttx_pkg::SpaceCode;
            end
         end else if (code inside {[ttx_pkg::MosaicFirst:ttx_pkg::MosaicLast]}) begin
            state_next.foreground_colour = code[2:0];
            state_next.mosaic_mode       = 1'b1;
            if (!at_cell.mosaic_mode) begin
               state_next.held_mosaic = ttx_pkg::SpaceCode;
            end
         end else if (code == ttx_pkg::CodeRelease) begin
            state_next.hold_active = 1'b0;
         end
      end else if (rsp.is_mosaic) begin
         state_next.held_mosaic = code;
      end
   end

endmodule

@@ design/teletext_row_attribute_decoder_unit.sv @@
// Teletext row attribute decoder: one received row byte in, one display cell out.
// Request channel: req_valid, req_stall, req_payload (code byte and row_start flag).
// Response channel: rsp_valid, rsp_stall, rsp_payload (code, mosaic, control, parity,
// colours, separated style).
// csr_write_enable/csr_write_data write the ignore_parity bit; write it only when idle.
// A request is taken into an input register, decoded combinationally against the
// attribute state, and the cell lands in the response register that drives rsp_valid.
// Throughput is one request per cycle while rsp_stall stays low, set by the single
// decode stage that updates the attribute state.
// While rsp_stall is high the response holds; the input register still accepts one
// more request, then req_stall rises until the response is taken.
// Synchronous reset clears both valids, ignore_parity and the attribute state
// (white on black, alphanumerics, no hold, contiguous, held mosaic space).
module teletext_row_attribute_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ttx_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ttx_pkg::rsp_type  rsp_payload,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   logic                    in_valid_ff, in_valid_in;
   ttx_pkg::req_type        in_data_ff, in_data_in;
   logic                    out_valid_ff, out_valid_in;
   ttx_pkg::rsp_type        out_data_ff, out_data_in;
   ttx_pkg::attr_state_type state_ff, state_in;
   logic                    ignore_ff, ignore_in;
   ttx_pkg::attr_state_type state_dec;
   ttx_pkg::rsp_type        rsp_dec;
   logic                    out_free;
   logic                    process;

   ttx_decode u_decode (
      .req           (in_data_ff),
      .ignore_parity (ignore_ff),
      .state_cur     (state_ff),
      .state_next    (state_dec),
      .rsp           (rsp_dec)
   );

   always_comb begin
      out_free    = !out_valid_ff || !rsp_stall;
      process     = in_valid_ff && out_free;
      req_stall   = in_valid_ff && !out_free;

      in_valid_in = req_stall ? in_valid_ff : req_valid;
      in_data_in  = (req_valid && !req_stall) ? req_payload : in_data_ff;

      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      out_data_in  = process ? rsp_dec : out_data_ff;
      state_in     = process ? state_dec : state_ff;
      ignore_in    = csr_write_enable ? csr_write_data : ignore_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ttx_pkg::AttrReset;
         ignore_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         ignore_ff    <= ignore_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

@@ verif/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit    = 400000;
   localparam int HoldoffCycles = 80;
   localparam int PhaseRequests = 64;

   class cell_scoreboard;
      ttx_pkg::attr_state_type attrs;
      logic                    ignore_parity;
      ttx_pkg::rsp_type        pending_cells[$];
      int                      errors;
      int                      requests;
      int                      control_cells;
      int                      mosaic_cells;
      int                      parity_faults;

      function new();
         attrs         = ttx_pkg::AttrReset;
         ignore_parity = 1'b0;
         errors        = 0;
         requests      = 0;
         control_cells = 0;
         mosaic_cells  = 0;
         parity_faults = 0;
      endfunction

      function ttx_pkg::rsp_type decode_cell(ttx_pkg::req_type r);
         logic             bad;
         logic [6:0]       code;
         ttx_pkg::rsp_type entry;
         if (r.row_start) begin
            attrs = ttx_pkg::AttrReset;
         end
         bad = ~(^r.code_byte);
         code = r.code_byte[6:0];
         if (bad && !ignore_parity) begin
            code = ttx_pkg::SpaceCode;
         end
         entry.is_control = (code < ttx_pkg::SpaceCode);
         entry.parity_error = bad;
         if (entry.is_control) begin
            case (code)
               ttx_pkg::CodeBlackBg: begin
                  attrs.background_colour = ttx_pkg::ColourBlack;
               end
               ttx_pkg::CodeNewBg: begin
                  attrs.background_colour = attrs.foreground_colour;
               end
               ttx_pkg::CodeHold: begin
                  attrs.hold_active = 1'b1;
               end
               ttx_pkg::CodeContiguous: begin
                  attrs.separated_mode = 1'b0;
               end
               ttx_pkg::CodeSeparated: begin
                  attrs.separated_mode = 1'b1;
               end
               default: begin
               end
            endcase
            if (attrs.hold_active && attrs.mosaic_mode && attrs.held_mosaic[5]) begin
               entry.shown_code = attrs.held_mosaic;
               entry.is_mosaic = 1'b1;
            end else begin
               entry.shown_code = ttx_pkg::SpaceCode;
               entry.is_mosaic = attrs.mosaic_mode;
            end
         end else begin
            entry.shown_code = code;
            entry.is_mosaic = attrs.mosaic_mode && code[5];
         end
         entry.foreground = attrs.foreground_colour;
         entry.background = attrs.background_colour;
         entry.separated_cell = attrs.separated_mode;
         if (entry.is_control) begin
            if (code >= ttx_pkg::AlphaFirst && code <= ttx_pkg::AlphaLast) begin
               attrs.foreground_colour = code[2:0];
               if (attrs.mosaic_mode) begin
                  attrs.held_mosaic = ttx_pkg::SpaceCode;
               end
               attrs.mosaic_mode = 1'b0;
            end else if (code >= ttx_pkg::MosaicFirst && code <= ttx_pkg::MosaicLast) begin
               attrs.foreground_colour = code[2:0];
               if (!attrs.mosaic_mode) begin
                  attrs.held_mosaic = ttx_pkg::SpaceCode;
               end
               attrs.mosaic_mode = 1'b1;
            end else if (code == ttx_pkg::CodeRelease) begin
               attrs.hold_active = 1'b0;
            end
         end else if (entry.is_mosaic) begin
            attrs.held_mosaic = code;
         end
         return entry;
      endfunction

      function void note_request(ttx_pkg::req_type r);
         ttx_pkg::rsp_type entry;
         entry = decode_cell(r);
         pending_cells.push_back(entry);
         requests++;
         control_cells += entry.is_control;
         mosaic_cells += entry.is_mosaic;
         parity_faults += entry.parity_error;
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(ttx_pkg::rsp_type got);
         ttx_pkg::rsp_type want;
         if (pending_cells.size() == 0) begin
            $display("%0t ns: unexpected cell, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_cells.pop_front();
         compare_field("shown_code", want.shown_code, got.shown_code);
         compare_field("is_mosaic", want.is_mosaic, got.is_mosaic);
         compare_field("is_control", want.is_control, got.is_control);
         compare_field("parity_error", want.parity_error, got.parity_error);
         compare_field("foreground", want.foreground, got.foreground);
         compare_field("background", want.background, got.background);
         compare_field("separated_cell", want.separated_cell, got.separated_cell);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ttx_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ttx_pkg::rsp_type rsp_payload;
   logic             csr_write_enable = 1'b0;
   logic             csr_write_data = 1'b0;

   logic    holdoff_arm = 1'b0;
   int      holdoff_left = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      cycle_count = 0;

   cell_scoreboard board = new();

   teletext_row_attribute_decoder_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_response(rsp_payload);
         end
         if (holdoff_arm && holdoff_left == 0) begin
            holdoff_left <= HoldoffCycles;
            rsp_stall <= 1'b1;
         end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   function automatic ttx_pkg::req_type make_request(logic [6:0] code, bit bad, bit row_first);
      ttx_pkg::req_type r;
      r.code_byte = {bad ? (^code) : ~(^code), code};
      r.row_start = row_first;
      return r;
   endfunction

   function automatic logic [6:0] pick_code();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) begin
         return 7'($urandom_range(31));
      end else if (roll < 40) begin
         case ($urandom_range(5))
            0: return 7'($urandom_range(ttx_pkg::AlphaFirst, ttx_pkg::AlphaLast));
            1: return 7'($urandom_range(ttx_pkg::MosaicFirst, ttx_pkg::MosaicLast));
            2: return ttx_pkg::CodeHold;
            3: return ttx_pkg::CodeRelease;
            4: return ($urandom_range(1) != 0) ? ttx_pkg::CodeSeparated
                                                : ttx_pkg::CodeContiguous;
            default: return ($urandom_range(1) != 0) ? ttx_pkg::CodeNewBg
                                                      : ttx_pkg::CodeBlackBg;
         endcase
      end
      return 7'($urandom_range(ttx_pkg::SpaceCode, 7'h7F));
   endfunction

   task automatic send_request(ttx_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      board.note_request(r);
   endtask

   task automatic send_code(logic [6:0] code, bit bad, bit row_first);
      send_request(make_request(code, bad, row_first));
   endtask

   task automatic send_raw(logic [7:0] value, bit row_first);
      ttx_pkg::req_type r;
      r.code_byte = value;
      r.row_start = row_first;
      send_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_cells.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_parity_bypass(logic value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.ignore_parity = value;
   endtask

   task automatic send_row(ref int sent);
      int len;
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
         send_code(pick_code(), $urandom_range(99) < 5, i == 0 || $urandom_range(99) == 0);
         sent++;
      end
   endtask

   task automatic run_phase(int phase);
      int sent;
      sent = 0;
      drain();
      set_parity_bypass(phase[0]);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      case (phase >> 1)
         1: send_idle_pct = 74;
         2: recv_stall_pct = 74;
         3: begin
            send_idle_pct = 7;
            recv_stall_pct = 7;
         end
         default: begin
         end
      endcase
      while (sent < PhaseRequests) begin
         if ($urandom_range(99) < 10) begin
            send_raw(8'($urandom_range(255)), $urandom_range(1));
            sent++;
         end else begin
            send_row(sent);
         end
      end
   endtask

   task automatic fill_under_holdoff();
      int saved_idle;
      drain();
      saved_idle = send_idle_pct;
      send_idle_pct = 0;
      holdoff_arm <= 1'b1;
      @(posedge clock);
      holdoff_arm <= 1'b0;
      for (int i = 0; i < 24; i++) begin
         send_code(pick_code(), $urandom_range(99) < 5, i == 0);
      end
      drain();
      send_idle_pct = saved_idle;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_parity_bypass(1'b0);

      send_code(7'h41, 0, 1);
      send_code(7'h03, 0, 0);
      send_code(7'h42, 0, 0);
      send_code(7'h12, 0, 0);
      send_code(7'h3F, 0, 0);
      send_code(ttx_pkg::CodeHold, 0, 0);
      send_code(ttx_pkg::CodeBlackBg, 0, 0);
      send_code(7'h13, 0, 0);
      send_code(ttx_pkg::CodeNewBg, 0, 0);
      send_code(ttx_pkg::CodeSeparated, 0, 0);
      send_code(7'h60, 0, 0);
      send_code(ttx_pkg::CodeContiguous, 0, 0);
      send_code(7'h45, 0, 0);
      send_code(ttx_pkg::CodeRelease, 0, 0);
      send_code(7'h08, 0, 0);
      send_code(ttx_pkg::AlphaFirst, 0, 0);
      send_code(ttx_pkg::CodeHold, 0, 0);
      send_code(ttx_pkg::MosaicLast, 0, 0);
      send_code(ttx_pkg::CodeHold, 0, 0);
      send_code(7'h12, 1, 0);
      send_raw(8'h00, 0);
      send_raw(8'hFF, 0);
      send_raw(8'h80, 0);
      send_raw(8'h7F, 0);
      send_code(7'h1B, 0, 1);

      fill_under_holdoff();
      for (int phase = 0; phase < 8; phase++) begin
         run_phase(phase);
      end
      drain();
      repeat (6) @(posedge clock);

      $display("ran %0d requests in eight phases under both parity settings and four idle mixes",
               board.requests);
      $display("cells seen: %0d attribute, %0d mosaic, %0d with parity faults",
               board.control_cells, board.mosaic_cells, board.parity_faults);
      if (board.errors == 0 && board.pending_cells.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
